/* hw/rtl/cbts_pkg.sv */
// shared types, constants and the timing word packing for the can bit timing search
// no dependencies
`default_nettype none

package cbts_pkg;

  localparam int ClkW   = 27;
  localparam int BaudW  = 20;
  localparam int CpbW   = 27;
  localparam int DivW   = 4;
  localparam int QmW    = 5;
  localparam int SegsW  = 5;
  localparam int QdW    = 10;
  localparam int ProdW  = 15;
  localparam int TwW    = 15;

  localparam logic [ClkW-1:0]  MainClkRst = 27'd48000000;
  localparam logic [DivW-1:0]  DivMax     = 4'd15;
  localparam logic [QmW-1:0]   QmMax      = 5'd31;
  localparam logic [SegsW-1:0] SegsMin    = 5'd3;
  localparam logic [SegsW-1:0] SegsMax    = 5'd17;
  localparam logic [1:0]       SjwMax     = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SEARCH,
    ST_OUT
  } cbts_state_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [DivW-1:0]  div;
    logic [QmW-1:0]   qm1;
    logic [SegsW-1:0] segs;
  } srch_res_t;

  function automatic logic [TwW-1:0] pack_timing(input logic [QmW-1:0] qm1,
                                                 input logic [SegsW-1:0] segs);
    logic [3:0] t;
    logic [3:0] seg1;
    logic [3:0] seg2;
    logic [1:0] sjw;
    t    = 4'(segs - SegsMin);
    seg1 = {1'b0, t[3:1]};
    seg2 = t - seg1;
    sjw  = (seg1 > {2'b00, SjwMax}) ? SjwMax : seg1[1:0];
    return {seg2[2:0], seg1, sjw, 1'b0, qm1};
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/cbts_div.sv */
// restoring divider, one quotient bit per cycle, gives clocks per bit
// depends on cbts_pkg
`default_nettype none

module cbts_div
  import cbts_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [ClkW-1:0]  dividend,
  input  wire logic [BaudW-1:0] divisor,
  output logic                  done,
  output logic [CpbW-1:0]       quotient
);

  localparam int CntW = $clog2(ClkW);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [BaudW-1:0]  dsr_r, dsr_nxt;
  logic [BaudW-1:0]  rem_r, rem_nxt;
  logic [ClkW-1:0]   quo_r, quo_nxt;
  logic [BaudW:0]    trial;
  logic [BaudW:0]    diff;
  logic              fits;

  assign trial = {rem_r, quo_r[ClkW-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CntW'(ClkW - 1);
      dsr_nxt  = divisor;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[BaudW-1:0] : trial[BaudW-1:0];
      quo_nxt = {quo_r[ClkW-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

/* hw/rtl/cbts_search.sv */
// candidate search, one divider/quanta/segment candidate checked per cycle
// depends on cbts_pkg
`default_nettype none

module cbts_search
  import cbts_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [CpbW-1:0] cpb,
  output srch_res_t            res
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              found_r, found_nxt;
  logic [CpbW-1:0]   cpb_r, cpb_nxt;
  logic [DivW-1:0]   div_r, div_nxt;
  logic [QmW-1:0]    qm1_r, qm1_nxt;
  logic [SegsW-1:0]  segs_r, segs_nxt;
  logic [QdW-1:0]    qd_r, qd_nxt;
  logic [ProdW-1:0]  prod;
  logic              hit;

  // qd_r tracks quanta * (div + 1)
  assign prod = ProdW'(segs_r) * ProdW'(qd_r);
  assign hit  = cpb_r == CpbW'(prod);

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    found_nxt = found_r;
    cpb_nxt   = cpb_r;
    div_nxt   = div_r;
    qm1_nxt   = qm1_r;
    segs_nxt  = segs_r;
    qd_nxt    = qd_r;
    if (start) begin
      busy_nxt  = 1'b1;
      found_nxt = 1'b0;
      cpb_nxt   = cpb;
      div_nxt   = '0;
      qm1_nxt   = '0;
      segs_nxt  = SegsMin;
      qd_nxt    = QdW'(1);
    end else if (busy_r) begin
      priority if (hit) begin
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
        found_nxt = 1'b1;
      end else if (segs_r != SegsMax) begin
        segs_nxt = segs_r + 1'b1;
      end else if (qm1_r != QmMax) begin
        segs_nxt = SegsMin;
        qm1_nxt  = qm1_r + 1'b1;
        qd_nxt   = qd_r + QdW'(div_r) + QdW'(1);
      end else if (div_r != DivMax) begin
        segs_nxt = SegsMin;
        qm1_nxt  = '0;
        div_nxt  = div_r + 1'b1;
        qd_nxt   = QdW'(div_r) + QdW'(2);
      end else begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      found_r <= found_nxt;
    end
    cpb_r  <= cpb_nxt;
    div_r  <= div_nxt;
    qm1_r  <= qm1_nxt;
    segs_r <= segs_nxt;
    qd_r   <= qd_nxt;
  end

  always_comb begin
    res.done  = done_r;
    res.found = found_r;
    res.div   = div_r;
    res.qm1   = qm1_r;
    res.segs  = segs_r;
  end

endmodule

`default_nettype wire

/* hw/rtl/can_bit_timing_search_top.sv */
// CAN bit timing search: takes a baud rate beat and returns one timing result beat.
// First it divides main_clock_hz by the baud rate in a restoring divider,
// then walks divider 0..15, quanta 1..32, segments 3..17 checking one candidate per
// clock with a single small multiplier, stopping at the first exact product match.
// A zero baud rate skips the divider and the search and answers in the next cycle.
// in_tready is low from acceptance until the result beat is taken.
// depends on cbts_pkg, cbts_div, cbts_search
`default_nettype none

module can_bit_timing_search_top
  import cbts_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [ClkW-1:0]  cfg_wr_data,  // main_clock_hz
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [23:0]      in_tdata,     // bitrate[19:0], zero pad
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [23:0]           out_tdata,    // prescaler[3:0], timing_word[18:4], zero pad
  output logic                  out_tuser     // found
);

  cbts_state_t       state_r, state_nxt;
  logic [ClkW-1:0]   main_clk_r;
  logic              found_r, found_nxt;
  logic [DivW-1:0]   presc_r, presc_nxt;
  logic [TwW-1:0]    tw_r, tw_nxt;
  logic [BaudW-1:0]  baud;
  logic              in_acc;
  logic              div_start;
  logic              div_done;
  logic [CpbW-1:0]   cpb;
  logic              srch_start;
  srch_res_t         srch;

  assign baud   = in_tdata[BaudW-1:0];
  assign in_acc = in_tvalid && in_tready;

  cbts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (main_clk_r),
    .divisor  (baud),
    .done     (div_done),
    .quotient (cpb)
  );

  cbts_search u_search (
    .clk   (clk),
    .rst_n (rst_n),
    .start (srch_start),
    .cpb   (cpb),
    .res   (srch)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = (baud == '0) ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (srch.done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    div_start  = 1'b0;
    srch_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        div_start = in_tvalid && (baud != '0);
      end
      ST_DIV: begin
        srch_start = div_done;
      end
      ST_SEARCH: begin
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_comb begin
    found_nxt = found_r;
    presc_nxt = presc_r;
    tw_nxt    = tw_r;
    if (state_r == ST_IDLE && in_acc) begin
      found_nxt = 1'b0;
      presc_nxt = '0;
      tw_nxt    = '0;
    end else if (state_r == ST_SEARCH && srch.done && srch.found) begin
      found_nxt = 1'b1;
      presc_nxt = srch.div;
      tw_nxt    = pack_timing(srch.qm1, srch.segs);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      main_clk_r <= MainClkRst;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) main_clk_r <= cfg_wr_data;
    end
    found_r <= found_nxt;
    presc_r <= presc_nxt;
    tw_r    <= tw_nxt;
  end

  assign out_tdata = {5'b0, tw_r, presc_r};
  assign out_tuser = found_r;

endmodule

`default_nettype wire

/* hw/rtl/cbts_checker.sv */
// port-level checks for the can bit timing search, bound to the top level
// depends on can_bit_timing_search_top
`default_nettype none

module cbts_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [23:0] in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic        out_tuser
);

  // one beat in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken again while a beat is in flight");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while a result waits");

  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == 24'd0))
    else $error("no-match result carries nonzero fields");

  a_zero_baud: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tdata[19:0] == 20'd0) |=> (out_tvalid && !out_tuser))
    else $error("zero baud rate did not answer with no match at once");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("result beat changed while stalled");

endmodule

bind can_bit_timing_search_top cbts_checker u_cbts_checker (.*);

`default_nettype wire

/* test/can_bit_timing_search_top_test.sv */
// testbench for can_bit_timing_search_top: drives baud rate beats under several clock settings
// and checks every result beat against a built-in search predictor
// depends on cbts_pkg and can_bit_timing_search_top
`timescale 1ns / 1ps

module can_bit_timing_search_top_test;
  import cbts_pkg::*;

  localparam int unsigned DIV_LAST    = 15;
  localparam int unsigned QUANTA_LAST = 32;
  localparam int unsigned SEGS_FIRST  = 3;
  localparam int unsigned SEGS_LAST   = 17;
  localparam int unsigned SJW_CAP     = 3;
  localparam logic [ClkW-1:0]  CLK_HZ_RESET = 27'd48000000;
  localparam logic [ClkW-1:0]  CLK_HZ_TOP   = 27'h7FFFFFF;
  localparam logic [BaudW-1:0] BAUD_TOP     = 20'hFFFFF;
  localparam int unsigned CYCLE_LIMIT = 5000000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic             found;
    logic [DivW-1:0]  prescaler;
    logic [TwW-1:0]   timing_word;
  } timing_res_t;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [ClkW-1:0]  cfg_wr_data = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [23:0]      in_tdata = '0;    // bitrate[19:0], zero pad
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [23:0]      out_tdata;        // prescaler[3:0], timing_word[18:4], zero pad
  logic             out_tuser;        // found

  timing_res_t      expected_timing[$];
  timing_res_t      want_res;
  logic [ClkW-1:0]  clk_hz_now = CLK_HZ_RESET;
  logic             no_idle = 1'b0;
  int unsigned      hold_cycles = 0;
  int unsigned      cycle_cnt = 0;
  int unsigned      err_cnt = 0;
  int unsigned      n_items = 0;
  int unsigned      n_found = 0;
  int unsigned      n_results = 0;
  int unsigned      n_cfg = 0;

  can_bit_timing_search_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic timing_res_t predict_timing(input logic [ClkW-1:0] hz,
                                                 input logic [BaudW-1:0] baud);
    timing_res_t r;
    int unsigned cpb;
    int unsigned t;
    int unsigned seg1;
    int unsigned seg2;
    int unsigned sjw;
    r = '0;
    if (baud == '0) return r;
    cpb = hz / baud;
    for (int unsigned d = 0; d <= DIV_LAST; d++) begin
      for (int unsigned q = 1; q <= QUANTA_LAST; q++) begin
        for (int unsigned s = SEGS_FIRST; s <= SEGS_LAST; s++) begin
          if (cpb == s * q * (d + 1)) begin
            t    = s - SEGS_FIRST;
            seg1 = t / 2;
            seg2 = t - seg1;
            sjw  = (seg1 > SJW_CAP) ? SJW_CAP : seg1;
            r.found       = 1'b1;
            r.prescaler   = DivW'(d);
            r.timing_word = {seg2[2:0], seg1[3:0], sjw[1:0], 6'((q - 1) & 32'h3F)};
            return r;
          end
        end
      end
    end
    return r;
  endfunction

  // mostly rates aimed at an exact candidate, the rest arbitrary
  function automatic logic [BaudW-1:0] pick_baud(input logic [ClkW-1:0] hz);
    int unsigned pick;
    int unsigned target;
    int unsigned baud;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      target = $urandom_range(SEGS_FIRST, SEGS_LAST) * $urandom_range(1, QUANTA_LAST)
               * $urandom_range(1, DIV_LAST + 1);
      baud = hz / target;
      if (baud == 0 || baud > BAUD_TOP) baud = $urandom_range(1, BAUD_TOP);
      return BaudW'(baud);
    end
    if (pick < 85) return BaudW'($urandom_range(0, BAUD_TOP));
    return BaudW'($urandom());
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want_v);
    $display("mismatch at result %0d: %s got 0x%0h want 0x%0h", n_results, what, got, want_v);
    err_cnt++;
  endtask

  task automatic send_baud(input logic [BaudW-1:0] baud);
    while (!no_idle && $urandom_range(0, 99) < 7) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(24 - BaudW){1'b0}}, baud};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_timing.push_back(predict_timing(clk_hz_now, baud));
    n_items++;
  endtask

  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    while (expected_timing.size() != 0) @(posedge clk);
  endtask

  task automatic write_main_clock(input logic [ClkW-1:0] hz);
    wait_results_done();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= hz;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    clk_hz_now = hz;
    n_cfg++;
  endtask

  task automatic test_default_clock();
    send_baud('0);
    send_baud(20'd1);
    send_baud(BAUD_TOP);
    send_baud(20'd1000000);
    send_baud(20'd500000);
    send_baud(20'd250000);
    send_baud(20'd125000);
    send_baud(20'd50000);
    send_baud(20'd10000);
    send_baud(20'd5515);
  endtask

  // receiver holds off while fast-matching beats keep coming
  task automatic test_output_stall();
    wait_results_done();
    hold_cycles <= HOLD_CYCLES;
    send_baud(20'd1000000);
    send_baud(20'd500000);
    send_baud(20'd250000);
    send_baud(20'd125000);
  endtask

  task automatic test_clock_extremes();
    write_main_clock(27'd1);
    send_baud(20'd1);
    send_baud('0);
    write_main_clock('0);
    send_baud(20'd1);
    write_main_clock(CLK_HZ_TOP);
    send_baud(BAUD_TOP);
    send_baud(20'd1);
    write_main_clock(27'd100000000);
    send_baud(20'd1000000);
  endtask

  // last divider with widest quanta and segments, smallest product, saturated sjw
  task automatic test_search_corners();
    write_main_clock(27'd8704000);
    send_baud(20'd1000);
    write_main_clock(27'd3);
    send_baud(20'd1);
    write_main_clock(27'd17);
    send_baud(20'd1);
  endtask

  task automatic test_random_phase(input logic [ClkW-1:0] hz, input int unsigned n_beats);
    write_main_clock(hz);
    repeat (n_beats) send_baud(pick_baud(hz));
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready  <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(0, 99) >= 7);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (expected_timing.size() == 0) begin
        report_mismatch("beat with nothing pending", 32'(out_tdata), 0);
      end else begin
        want_res = expected_timing.pop_front();
        if (want_res.found) n_found++;
        if (out_tuser !== want_res.found)
          report_mismatch("found", 32'(out_tuser), 32'(want_res.found));
        if (out_tdata[3:0] !== want_res.prescaler)
          report_mismatch("prescaler", 32'(out_tdata[3:0]), 32'(want_res.prescaler));
        if (out_tdata[18:4] !== want_res.timing_word)
          report_mismatch("timing_word", 32'(out_tdata[18:4]), 32'(want_res.timing_word));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results pending", cycle_cnt,
               expected_timing.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_default_clock();
    test_output_stall();
    test_clock_extremes();
    test_search_corners();
    test_random_phase(ClkW'($urandom_range(1, 100000000)), 18);
    wait_results_done();
    no_idle <= 1'b1;
    test_random_phase(27'd16000000, 18);
    wait_results_done();
    no_idle <= 1'b0;
    test_random_phase(27'd100000000, 18);
    test_random_phase(ClkW'($urandom_range(0, CLK_HZ_TOP)), 18);
    wait_results_done();
    repeat (40) @(posedge clk);
    $display("checked %0d baud rate beats across %0d clock register settings", n_items, n_cfg);
    $display("%0d beats found a timing, %0d had no match", n_found, n_results - n_found);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
